>>> rtl/wdir_pkg.sv
// wdir_pkg: shared widths, constants, arctangent table and word types
// for the wind direction core; depends on nothing
package wdir_pkg;

  localparam int unsigned COMP_WIDTH     = 16;
  localparam int unsigned ANGLE_STEPS    = 18;
  localparam int unsigned PRESCALE_SHIFT = 24;
  localparam int unsigned DATA_WIDTH     = COMP_WIDTH + PRESCALE_SHIFT + 4;
  localparam int unsigned ANGLE_WIDTH    = 32;
  localparam int unsigned DIR_WIDTH      = 15;
  localparam int unsigned PROD_WIDTH     = ANGLE_WIDTH + DIR_WIDTH;
  localparam int unsigned PIPE_LATENCY   = ANGLE_STEPS + 3;

  localparam logic [DIR_WIDTH-1:0]   DIR_UNITS = 15'd23040;
  localparam logic [DIR_WIDTH-1:0]   DIR_HALF  = DIR_UNITS / 2;
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [PROD_WIDTH-1:0]  ROUND_BIAS = PROD_WIDTH'(64'h8000_0000);

  // atan(2^-i), full turn = 2^32
  localparam logic [ANGLE_WIDTH-1:0] ATAN_TAB [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] east_comp;
    logic signed [COMP_WIDTH-1:0] north_comp;
    logic                         east_missing;
    logic                         north_missing;
  } wdir_in_t;

  typedef struct packed {
    logic [DIR_WIDTH-1:0] direction;
    logic                 result_missing;
  } wdir_out_t;

  typedef struct packed {
    logic valid;
    logic missing;
    logic both_zero;
  } wdir_tag_t;

endpackage

>>> rtl/wdir_cordic.sv
// wdir_cordic: unrolled vectoring cordic, one micro-rotation per register stage
// depends on wdir_pkg
module wdir_cordic (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  wdir_pkg::wdir_tag_t                          tag_i,
  input  logic signed [wdir_pkg::DATA_WIDTH-1:0]       x_i,
  input  logic signed [wdir_pkg::DATA_WIDTH-1:0]       y_i,
  input  logic        [wdir_pkg::ANGLE_WIDTH-1:0]      z_i,
  output wdir_pkg::wdir_tag_t                          tag_o,
  output logic        [wdir_pkg::ANGLE_WIDTH-1:0]      z_o
);
  import wdir_pkg::*;

  wdir_tag_t                    tag_s [ANGLE_STEPS+1];
  logic signed [DATA_WIDTH-1:0] x_s   [ANGLE_STEPS+1];
  logic signed [DATA_WIDTH-1:0] y_s   [ANGLE_STEPS+1];
  logic [ANGLE_WIDTH-1:0]       z_s   [ANGLE_STEPS+1];

  assign tag_s[0] = tag_i;
  assign x_s[0]   = x_i;
  assign y_s[0]   = y_i;
  assign z_s[0]   = z_i;

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_step
    wdir_tag_t                    tag_q;
    logic signed [DATA_WIDTH-1:0] x_d, x_q, y_d, y_q;
    logic [ANGLE_WIDTH-1:0]       z_d, z_q;

    always_comb begin
      if (!y_s[g][DATA_WIDTH-1]) begin
        x_d = x_s[g] + (y_s[g] >>> g);
        y_d = y_s[g] - (x_s[g] >>> g);
        z_d = z_s[g] + ATAN_TAB[g];
      end else begin
        x_d = x_s[g] - (y_s[g] >>> g);
        y_d = y_s[g] + (x_s[g] >>> g);
        z_d = z_s[g] - ATAN_TAB[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q <= '0;
      end else begin
        tag_q <= tag_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end

    assign tag_s[g+1] = tag_q;
    assign x_s[g+1]   = x_q;
    assign y_s[g+1]   = y_q;
    assign z_s[g+1]   = z_q;
  end

  assign tag_o = tag_s[ANGLE_STEPS];
  assign z_o   = z_s[ANGLE_STEPS];

  // x starts non-negative and only grows in magnitude
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_s[1].valid |-> !x_s[1][DATA_WIDTH-1])
    else $error("cordic x went negative");

  a_tag_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_i.valid |-> ##ANGLE_STEPS tag_o.valid)
    else $error("cordic word lost");

endmodule

>>> rtl/wind_direction_from_uv_core.sv
// wind_direction_from_uv_core: top level, input scaling, cordic pipeline and
// scaling of the binary angle to 1/64 degree; depends on wdir_pkg, wdir_cordic
//
// One word enters on every clock where start is high (busy is always low) and
// its result appears on rsp_o with done_o high after passing one input
// register, one register per cordic micro-rotation, one for the
// angle-to-degree multiply and one output register. Results come in input
// order, one per word, and the receiver must take each on the cycle done_o is
// high. A missing component gives direction 0 with result_missing set; both
// components zero gives 180 degrees.
module wind_direction_from_uv_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wdir_pkg::wdir_in_t req_i,
  output logic               done_o,
  output wdir_pkg::wdir_out_t rsp_o
);
  import wdir_pkg::*;

  logic signed [DATA_WIDTH-1:0] u_sc, v_sc, x_d, y_d, x_q, y_q;
  logic [ANGLE_WIDTH-1:0]       z_d, z_q, z_c;
  wdir_tag_t                    tag_d, tag_q, tag_c, tag_m_q;
  logic [PROD_WIDTH-1:0]        prod_q, prod_rnd;
  logic [DIR_WIDTH-1:0]         dir_raw;
  wdir_out_t                    rsp_d, rsp_q;
  logic                         done_q;

  assign busy = 1'b0;

  // scale components into the cordic word and fold into the right half plane
  always_comb begin
    u_sc = DATA_WIDTH'(req_i.east_comp) <<< PRESCALE_SHIFT;
    v_sc = DATA_WIDTH'(req_i.north_comp) <<< PRESCALE_SHIFT;
    if (v_sc > 0) begin
      x_d = v_sc;
      y_d = u_sc;
      z_d = HALF_TURN;
    end else begin
      x_d = -v_sc;
      y_d = -u_sc;
      z_d = '0;
    end
    tag_d.valid     = start && !busy;
    tag_d.missing   = req_i.east_missing || req_i.north_missing;
    tag_d.both_zero = (req_i.east_comp == '0) && (req_i.north_comp == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      tag_m_q <= '0;
      done_q  <= 1'b0;
    end else begin
      tag_q   <= tag_d;
      tag_m_q <= tag_c;
      done_q  <= tag_m_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    prod_q <= PROD_WIDTH'(z_c) * PROD_WIDTH'(DIR_UNITS);
    rsp_q  <= rsp_d;
  end

  wdir_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .x_i    (x_q),
    .y_i    (y_q),
    .z_i    (z_q),
    .tag_o  (tag_c),
    .z_o    (z_c)
  );

  // round to nearest 1/64 degree, 360 wraps to 0
  always_comb begin
    prod_rnd = prod_q + ROUND_BIAS;
    dir_raw  = prod_rnd[PROD_WIDTH-1:ANGLE_WIDTH];
    if (tag_m_q.missing) begin
      rsp_d.direction      = '0;
      rsp_d.result_missing = 1'b1;
    end else if (tag_m_q.both_zero) begin
      rsp_d.direction      = DIR_HALF;
      rsp_d.result_missing = 1'b0;
    end else begin
      rsp_d.direction      = (dir_raw >= DIR_UNITS) ? '0 : dir_raw;
      rsp_d.result_missing = 1'b0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LATENCY done_o)
    else $error("result word not delivered at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##PIPE_LATENCY !done_o)
    else $error("result word without an input word");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.direction < DIR_UNITS))
    else $error("direction out of range");

  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.result_missing) |-> (rsp_o.direction == '0))
    else $error("missing result with nonzero direction");

endmodule
